>>> hw/rtl/periodic_cell_image_point_top_assert.svh
// Assertion macros used by the checker file of the cell imaging block.
// Each macro expands to one labeled concurrent assertion on the rising edge of clk.
`ifndef PERIODIC_CELL_IMAGE_POINT_TOP_ASSERT_SVH
`define PERIODIC_CELL_IMAGE_POINT_TOP_ASSERT_SVH

// Checked only outside reset.
`define PCIP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define PCIP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/pcip_pkg.sv
// ----------------------------------------------------------------------------
// pcip_pkg: shared definitions for the periodic cell imaging block
// Holds the widths, the register indexes, the sequencer types and the matrix
// entry helper.
// ----------------------------------------------------------------------------
package pcip_pkg;

  // Field and register widths.
  localparam int COORD_W   = 32;
  localparam int SHIFT_W   = 8;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int ENTRY_W   = 32;

  // Shared multiplier: signed operands and 27-bit magnitude digits.
  localparam int OPW  = 55;
  localparam int MAGW = 54;
  localparam int DIGW = 27;
  localparam int ACCW = 104;

  // Internal value widths.
  localparam int P2W  = 36;
  localparam int FLW  = 28;
  localparam int HW   = 32;
  localparam int RW   = 16;
  localparam int LSW  = 34;

  // Bit positions in the fractional coordinate sum: 16 + 24 fraction bits + 1 for doubling.
  localparam int FL_LSB  = 41;
  localparam int R_LSB   = 25;
  localparam int HALF_Q16 = 32768;
  localparam int L_SHIFT  = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CELL_XX_XY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_XZ_YY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_YZ_ZZ    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_XX_XY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_XZ_YY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_YZ_ZZ = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PERIODIC_EN   = 3'd6;

  // Opcodes.
  localparam logic OP_POINT  = 1'b0;
  localparam logic OP_VECTOR = 1'b1;

  // Neighbor offset codes: minus one, zero, plus one.
  localparam logic [1:0] LOFS_MINUS = 2'd0;
  localparam logic [1:0] LOFS_ZERO  = 2'd1;
  localparam logic [1:0] LOFS_PLUS  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_CAPTURE,
    ST_OUT
  } state_t;

  // Which sum of products the shared unit is working on.
  typedef enum logic [1:0] {
    GR_FRAC,
    GR_BASE,
    GR_SCORE,
    GR_SHIFT
  } group_t;

  typedef logic [2:0][CFG_W-1:0] mat_regs_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic       issue;
    logic       clear;
    logic [1:0] digit;
  } mac_ctl_t;

  // Upper-triangular entry (row, col) from three packed registers.
  function automatic logic signed [ENTRY_W-1:0] mat_entry(mat_regs_t m, logic [1:0] row,
                                                         logic [1:0] col);
    logic signed [ENTRY_W-1:0] v;
    unique case ({row, col})
      4'b0000: v = m[0][CFG_W-1:ENTRY_W];
      4'b0001: v = m[0][ENTRY_W-1:0];
      4'b0010: v = m[1][CFG_W-1:ENTRY_W];
      4'b0101: v = m[1][ENTRY_W-1:0];
      4'b0110: v = m[2][CFG_W-1:ENTRY_W];
      4'b1010: v = m[2][ENTRY_W-1:0];
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/pcip_mac.sv
// ----------------------------------------------------------------------------
// pcip_mac: shared digit-serial multiply-accumulate unit
// Multiplies two signed operands one pair of 27-bit magnitude digits per
// cycle and adds the shifted partial product into a wide accumulator.
// ----------------------------------------------------------------------------
module pcip_mac import pcip_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  mac_ctl_t               ctl,
  input  logic signed [OPW-1:0]  opa,
  input  logic signed [OPW-1:0]  opb,
  output logic signed [ACCW-1:0] acc
);

  logic signed [OPW-1:0]  nega, negb;
  logic [MAGW-1:0]        amag, bmag;
  logic [DIGW-1:0]        adig, bdig;
  logic [2*DIGW-1:0]      pp;
  logic                   pp_neg;
  logic [1:0]             pp_sh;
  logic                   pp_valid;
  logic signed [ACCW-1:0] term;

  // Magnitudes and the digits picked for this cycle.
  always_comb begin
    nega = -opa;
    negb = -opb;
    amag = opa[OPW-1] ? nega[MAGW-1:0] : opa[MAGW-1:0];
    bmag = opb[OPW-1] ? negb[MAGW-1:0] : opb[MAGW-1:0];
    adig = ctl.digit[0] ? amag[MAGW-1:DIGW] : amag[DIGW-1:0];
    bdig = ctl.digit[1] ? bmag[MAGW-1:DIGW] : bmag[DIGW-1:0];
  end

  // Partial product register.
  always_ff @(posedge clk) begin
    pp     <= adig * bdig;
    pp_neg <= opa[OPW-1] ^ opb[OPW-1];
    pp_sh  <= {1'b0, ctl.digit[0]} + {1'b0, ctl.digit[1]};
    if (rst) begin
      pp_valid <= 1'b0;
    end else begin
      pp_valid <= ctl.issue;
    end
  end

  // Align the partial product to its digit weight.
  always_comb begin
    unique case (pp_sh)
      2'd0:    term = ACCW'(pp);
      2'd1:    term = ACCW'(pp) << DIGW;
      2'd2:    term = ACCW'(pp) << (2 * DIGW);
      default: term = '0;
    endcase
  end

  // Accumulator.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (pp_valid) begin
      acc <= pp_neg ? acc - term : acc + term;
    end
  end

endmodule

>>> hw/rtl/periodic_cell_image_point_top.sv
// ----------------------------------------------------------------------------
// periodic_cell_image_point_top: minimum-image and cell-shift imaging
// Images a point or a displacement vector into a triclinic periodic cell.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one point or vector per
//   beat; the output channel (out_valid / out_stall) returns one imaged
//   result per beat. The block takes one item at a time: in_stall is high
//   from the accepting edge until the result beat has been taken.
//   With the periodic cell enabled, vector items always run the nearest
//   search. With the cell disabled the input is returned in the cycle
//   after accept. All products go through one shared 27x27-bit digit
//   multiplier, which takes each product as four digit pairs; each sum
//   has three products and a drain and a capture state, and the 27
//   neighbor scores are 27 such sums. The configuration port (cfg_we,
//   cfg_index, cfg_data) must be written only while the block is idle;
//   the block itself does not enforce this. Reset clears the configuration
//   registers and the sequencer. While the receiver stalls, the result
//   stays on the output and no new item is accepted.
// ----------------------------------------------------------------------------
module periodic_cell_image_point_top import pcip_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       opcode,
  input  logic signed [COORD_W-1:0]  pos_x,
  input  logic signed [COORD_W-1:0]  pos_y,
  input  logic signed [COORD_W-1:0]  pos_z,
  input  logic signed [SHIFT_W-1:0]  shift_a,
  input  logic signed [SHIFT_W-1:0]  shift_b,
  input  logic signed [SHIFT_W-1:0]  shift_c,
  input  logic                       origin_offset,
  input  logic                       nearest_to_center,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [COORD_W-1:0]  out_x,
  output logic signed [COORD_W-1:0]  out_y,
  output logic signed [COORD_W-1:0]  out_z,
  output logic                       saturated,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam logic signed [ACCW-1:0] OUT_MAX =
    {{(ACCW-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [ACCW-1:0] OUT_MIN =
    {{(ACCW-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  // Configuration registers.
  mat_regs_t cell_mat, inv;
  logic      enable;

  // Sequencer.
  state_t state, state_next;
  group_t group;
  logic [1:0] row, col, dig;
  logic [1:0] la, lb, lc;

  // Item registers.
  logic signed [COORD_W-1:0] p [3];
  logic signed [SHIFT_W-1:0] k [3];
  logic signed [P2W-1:0]     p2 [3];
  logic signed [FLW-1:0]     fl [3];
  logic [RW-1:0]             rem [3];
  logic signed [OPW-1:0]     e0 [3];
  logic [1:0]                m [3];
  logic                      origin, nearest;
  logic signed [ACCW-1:0]    best;
  logic signed [COORD_W-1:0] res [3];
  logic                      sat;

  // Datapath helpers.
  mac_ctl_t               mac_ctl;
  logic signed [OPW-1:0]  opa, opb;
  logic signed [ACCW-1:0] acc;
  logic signed [ENTRY_W-1:0] u_ij, r_ij;
  logic signed [LSW-1:0]  lsum;
  logic signed [OPW-1:0]  e_cur;
  logic signed [HW-1:0]   h_cur;
  logic signed [P2W-1:0]  p2_in [3];
  logic signed [COORD_W-1:0] pos_in [3];
  logic signed [ACCW-1:0] o_diff, o_val;
  logic                   in_beat, first_cand, last_cand;

  // Signed value of a neighbor offset code.
  function automatic logic signed [HW-1:0] lofs_val(logic [1:0] code);
    logic signed [HW-1:0] v;
    unique case (code)
      LOFS_MINUS: v = -HW'(1);
      LOFS_PLUS:  v = HW'(1);
      default:    v = '0;
    endcase
    return v;
  endfunction

  // Cell entry times a neighbor offset code.
  function automatic logic signed [LSW-1:0] lofs_mul(logic [1:0] code,
                                                     logic signed [ENTRY_W-1:0] u);
    logic signed [LSW-1:0] v;
    unique case (code)
      LOFS_MINUS: v = -LSW'(u);
      LOFS_PLUS:  v = LSW'(u);
      default:    v = '0;
    endcase
    return v;
  endfunction

  assign in_beat    = in_valid && !in_stall;
  assign first_cand = (la == LOFS_MINUS) && (lb == LOFS_MINUS) && (lc == LOFS_MINUS);
  assign last_cand  = (la == LOFS_PLUS) && (lb == LOFS_PLUS) && (lc == LOFS_PLUS);

  assign pos_in[0] = pos_x;
  assign pos_in[1] = pos_y;
  assign pos_in[2] = pos_z;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_mat <= '0;
      inv      <= '0;
      enable   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELL_XX_XY:    cell_mat[0] <= cfg_data;
        REG_CELL_XZ_YY:    cell_mat[1] <= cfg_data;
        REG_CELL_YZ_ZZ:    cell_mat[2] <= cfg_data;
        REG_INVERSE_XX_XY: inv[0]      <= cfg_data;
        REG_INVERSE_XZ_YY: inv[1]      <= cfg_data;
        REG_INVERSE_YZ_ZZ: inv[2]      <= cfg_data;
        REG_PERIODIC_EN:   enable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Doubled point; a vector is moved to the cell center first.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p2_in[i] = P2W'(pos_in[i]) <<< 1;
      if (opcode == OP_VECTOR) begin
        p2_in[i] = p2_in[i] + P2W'(mat_entry(cell_mat, 2'(i), 2'd0))
                            + P2W'(mat_entry(cell_mat, 2'(i), 2'd1))
                            + P2W'(mat_entry(cell_mat, 2'(i), 2'd2));
      end
    end
  end

  // Operands of the shared multiplier.
  always_comb begin
    u_ij  = mat_entry(cell_mat, row, col);
    r_ij  = mat_entry(inv, row, col);
    lsum  = lofs_mul(la, mat_entry(cell_mat, col, 2'd0))
          + lofs_mul(lb, mat_entry(cell_mat, col, 2'd1))
          + lofs_mul(lc, mat_entry(cell_mat, col, 2'd2));
    e_cur = e0[col] + (OPW'(lsum) <<< L_SHIFT);
    h_cur = ((HW'(fl[col]) - lofs_val(m[col]) - HW'(k[col])) <<< 1)
          + HW'($signed({1'b0, origin}));
    unique case (group)
      GR_FRAC: begin
        opa = OPW'(r_ij);
        opb = OPW'(p2[col]);
      end
      GR_BASE: begin
        opa = OPW'(u_ij);
        opb = OPW'($signed({1'b0, rem[col]})) - OPW'(HALF_Q16);
      end
      GR_SCORE: begin
        opa = e_cur;
        opb = e_cur;
      end
      default: begin
        opa = OPW'(u_ij);
        opb = OPW'(h_cur);
      end
    endcase
  end

  // Final coordinate: floor((2p - U*H) / 2).
  always_comb begin
    o_diff = (ACCW'(p[row]) <<< 1) - acc;
    o_val  = o_diff >>> 1;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = enable ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL: begin
        if (dig == 2'd3 && col == 2'd2) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_CAPTURE;
      ST_CAPTURE: begin
        state_next = (group == GR_SHIFT && row == 2'd2) ? ST_OUT : ST_MUL;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and multiplier control.
  always_comb begin
    in_stall      = (state != ST_IDLE);
    out_valid     = (state == ST_OUT);
    mac_ctl.issue = (state == ST_MUL);
    mac_ctl.clear = (state == ST_IDLE) || (state == ST_CAPTURE);
    mac_ctl.digit = dig;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer counters and item datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      group <= GR_FRAC;
      row   <= '0;
      col   <= '0;
      dig   <= '0;
      la    <= LOFS_MINUS;
      lb    <= LOFS_MINUS;
      lc    <= LOFS_MINUS;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            group   <= GR_FRAC;
            row     <= '0;
            col     <= '0;
            dig     <= '0;
            origin  <= (opcode == OP_VECTOR) ? 1'b0 : origin_offset;
            nearest <= (opcode == OP_VECTOR) ? 1'b1 : nearest_to_center;
            sat     <= 1'b0;
            k[0]    <= (opcode == OP_VECTOR) ? '0 : shift_a;
            k[1]    <= (opcode == OP_VECTOR) ? '0 : shift_b;
            k[2]    <= (opcode == OP_VECTOR) ? '0 : shift_c;
            for (int i = 0; i < 3; i++) begin
              p[i]   <= pos_in[i];
              p2[i]  <= p2_in[i];
              m[i]   <= LOFS_ZERO;
              res[i] <= pos_in[i];
            end
          end
        end
        ST_MUL: begin
          dig <= dig + 2'd1;
          if (dig == 2'd3) begin
            col <= (col == 2'd2) ? 2'd0 : col + 2'd1;
          end
        end
        ST_CAPTURE: begin
          unique case (group)
            GR_FRAC: begin
              fl[row]  <= acc[FL_LSB +: FLW];
              rem[row] <= acc[R_LSB +: RW];
              if (row == 2'd2) begin
                row   <= '0;
                group <= nearest ? GR_BASE : GR_SHIFT;
              end else begin
                row <= row + 2'd1;
              end
            end
            GR_BASE: begin
              e0[row] <= acc[OPW-1:0];
              if (row == 2'd2) begin
                row   <= '0;
                group <= GR_SCORE;
                la    <= LOFS_MINUS;
                lb    <= LOFS_MINUS;
                lc    <= LOFS_MINUS;
              end else begin
                row <= row + 2'd1;
              end
            end
            GR_SCORE: begin
              // First strict minimum wins.
              if (first_cand || acc < best) begin
                best <= acc;
                m[0] <= la;
                m[1] <= lb;
                m[2] <= lc;
              end
              if (last_cand) begin
                group <= GR_SHIFT;
              end else if (lc != LOFS_PLUS) begin
                lc <= lc + 2'd1;
              end else begin
                lc <= LOFS_MINUS;
                if (lb != LOFS_PLUS) begin
                  lb <= lb + 2'd1;
                end else begin
                  lb <= LOFS_MINUS;
                  la <= la + 2'd1;
                end
              end
            end
            default: begin
              // Saturate the imaged coordinate.
              if (o_val > OUT_MAX) begin
                res[row] <= OUT_MAX[COORD_W-1:0];
                sat      <= 1'b1;
              end else if (o_val < OUT_MIN) begin
                res[row] <= OUT_MIN[COORD_W-1:0];
                sat      <= 1'b1;
              end else begin
                res[row] <= o_val[COORD_W-1:0];
              end
              row <= (row == 2'd2) ? 2'd0 : row + 2'd1;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];
  assign saturated = sat;

  pcip_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .opa (opa),
    .opb (opb),
    .acc (acc)
  );

endmodule

>>> hw/rtl/pcip_checker.sv
// ----------------------------------------------------------------------------
// pcip_checker: port-level checks for the periodic cell imaging block
// Watches the two channels of the top level over time.
// ----------------------------------------------------------------------------
`include "periodic_cell_image_point_top_assert.svh"

module pcip_checker import pcip_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [COORD_W-1:0] out_x,
  input logic                      saturated
);

  // A stalled result beat keeps its payload.
  `PCIP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(saturated), "stalled result changed")

  // An accepted beat makes the block busy on the next cycle.
  `PCIP_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "accepted a second item at once")

  // No new item is taken while a result waits.
  `PCIP_ASSERT(a_one_in_flight, out_valid |-> in_stall, "input open while result pending")

  // Reset leaves no result on the output.
  `PCIP_ASSERT_ALWAYS(a_reset_clear, rst |=> !out_valid, "result valid after reset")

endmodule

bind periodic_cell_image_point_top pcip_checker u_pcip_checker (.*);

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking test of the periodic cell imaging block
// Loads a series of triclinic cells (valid, degenerate and extreme register
// contents) while the block is idle. Each phase sends points and vectors
// through the valid/stall channels with random gaps on both sides. Every
// result beat is checked against an exact integer predictor of the imaging.
// ----------------------------------------------------------------------------
module testbench;
  import pcip_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 600;

  typedef struct {
    logic                      op;
    logic signed [COORD_W-1:0] x, y, z;
    logic signed [SHIFT_W-1:0] a, b, c;
    logic                      org;
    logic                      near;
  } point_t;

  typedef struct {
    logic signed [COORD_W-1:0] x, y, z;
    logic                      sat;
  } image_t;

  typedef logic signed [127:0] wide_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic opcode = 1'b0;
  logic signed [COORD_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [SHIFT_W-1:0] shift_a = '0, shift_b = '0, shift_c = '0;
  logic origin_offset = 1'b0, nearest_to_center = 1'b0;
  logic out_valid, out_stall = 1'b1;
  logic signed [COORD_W-1:0] out_x, out_y, out_z;
  logic saturated;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Shadow copy of the register file.
  logic [CFG_W-1:0] box_reg [3];
  logic [CFG_W-1:0] inv_reg [3];
  logic             wrap_on;

  point_t pend_q [$];
  image_t image_q [$];
  int errors = 0, n_in = 0, n_out = 0, n_sat = 0, n_vec = 0;
  int in_gap = 0, out_hold = 0, idle_cnt = 0;
  bit in_took = 0, quiet = 0;

  always #5 clk = ~clk;

  periodic_cell_image_point_top dut (.*);

  // Short gaps mostly, an occasional long one, none in quiet phases.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (quiet) return 0;
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Exact imaging of one beat against the current register shadow.
  function automatic image_t image_of(point_t it);
    longint u [3][3], ri [3][3];
    longint p [3], k [3], p2 [3], fl [3], rem [3], h [3], mm [3], t [3];
    longint org, e;
    wide_t f, ds, best, d, o, wa, wb, hi_lim, lo_lim;
    bit vec, near, have;
    image_t res;
    vec = it.op == OP_VECTOR;
    near = it.near;
    org = it.org;
    p[0] = it.x; p[1] = it.y; p[2] = it.z;
    k[0] = it.a; k[1] = it.b; k[2] = it.c;
    res.sat = 1'b0;
    if (!wrap_on) begin
      res.x = it.x; res.y = it.y; res.z = it.z;
      return res;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        u[i][j] = 0;
        ri[i][j] = 0;
      end
    u[0][0] = $signed(box_reg[0][63:32]); u[0][1] = $signed(box_reg[0][31:0]);
    u[0][2] = $signed(box_reg[1][63:32]); u[1][1] = $signed(box_reg[1][31:0]);
    u[1][2] = $signed(box_reg[2][63:32]); u[2][2] = $signed(box_reg[2][31:0]);
    ri[0][0] = $signed(inv_reg[0][63:32]); ri[0][1] = $signed(inv_reg[0][31:0]);
    ri[0][2] = $signed(inv_reg[1][63:32]); ri[1][1] = $signed(inv_reg[1][31:0]);
    ri[1][2] = $signed(inv_reg[2][63:32]); ri[2][2] = $signed(inv_reg[2][31:0]);
    if (vec) begin
      near = 1;
      org = 0;
      k[0] = 0; k[1] = 0; k[2] = 0;
    end
    // Doubled point, with the doubled cell center added for vectors.
    for (int i = 0; i < 3; i++) begin
      p2[i] = 2 * p[i];
      if (vec) p2[i] += u[i][0] + u[i][1] + u[i][2];
    end
    // Fractional coordinates split into floor and a 16-bit remainder.
    for (int i = 0; i < 3; i++) begin
      f = 0;
      for (int j = 0; j < 3; j++) begin
        wa = ri[i][j];
        wb = p2[j];
        f = f + wa * wb;
      end
      fl[i] = longint'(f >>> FL_LSB);
      rem[i] = longint'(f[FL_LSB-1:R_LSB]);
      mm[i] = 0;
    end
    // Nearest of the 27 neighbor images to the center; first strict minimum.
    if (near) begin
      have = 0;
      best = 0;
      for (int lx = -1; lx <= 1; lx++)
        for (int ly = -1; ly <= 1; ly++)
          for (int lz = -1; lz <= 1; lz++) begin
            t[0] = rem[0] + 65536 * lx - HALF_Q16;
            t[1] = rem[1] + 65536 * ly - HALF_Q16;
            t[2] = rem[2] + 65536 * lz - HALF_Q16;
            ds = 0;
            for (int i = 0; i < 3; i++) begin
              e = u[i][0] * t[0] + u[i][1] * t[1] + u[i][2] * t[2];
              wa = e;
              ds = ds + wa * wa;
            end
            if (!have || ds < best) begin
              have = 1;
              best = ds;
              mm[0] = lx; mm[1] = ly; mm[2] = lz;
            end
          end
    end
    for (int i = 0; i < 3; i++) h[i] = 2 * (fl[i] - mm[i] - k[i]) + org;
    // Shift by whole and half cells, floor the half bit, then saturate.
    hi_lim = 64'sd2147483647;
    lo_lim = -64'sd2147483648;
    for (int i = 0; i < 3; i++) begin
      d = 0;
      for (int j = 0; j < 3; j++) begin
        wa = u[i][j];
        wb = h[j];
        d = d + wa * wb;
      end
      wa = 2 * p[i];
      o = (wa - d) >>> 1;
      if (o > hi_lim) begin
        o = hi_lim;
        res.sat = 1'b1;
      end else if (o < lo_lim) begin
        o = lo_lim;
        res.sat = 1'b1;
      end
      if (i == 0) res.x = o[31:0];
      else if (i == 1) res.y = o[31:0];
      else res.z = o[31:0];
    end
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("MISMATCH beat %0d %s: got %0d expected %0d", n_out, what, got, want);
  endtask

  // Input driver: holds a stalled beat, otherwise gaps or loads the next one.
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        point_t it;
        it = pend_q.pop_front();
        opcode <= it.op;
        pos_x <= it.x; pos_y <= it.y; pos_z <= it.z;
        shift_a <= it.a; shift_b <= it.b; shift_c <= it.c;
        origin_offset <= it.org;
        nearest_to_center <= it.near;
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall pattern.
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold <= out_hold - 1;
    end else begin
      out_stall <= 1'b0;
      out_hold <= pick_gap();
    end
  end

  // Monitor: predicts on each accepted input beat, checks each result beat.
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall && !rst;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
      if (in_valid && !in_stall) begin
        point_t it;
        it.op = opcode; it.x = pos_x; it.y = pos_y; it.z = pos_z;
        it.a = shift_a; it.b = shift_b; it.c = shift_c;
        it.org = origin_offset; it.near = nearest_to_center;
        image_q.push_back(image_of(it));
        n_in++;
        if (opcode == OP_VECTOR) n_vec++;
      end
      if (out_valid && !out_stall) begin
        n_out++;
        if (saturated) n_sat++;
        if (image_q.size() == 0) begin
          errors++;
          $display("MISMATCH result beat %0d arrived with nothing expected", n_out);
        end else begin
          image_t want;
          want = image_q.pop_front();
          if (out_x !== want.x) report("out_x", out_x, want.x);
          if (out_y !== want.y) report("out_y", out_y, want.y);
          if (out_z !== want.z) report("out_z", out_z, want.z);
          if (saturated !== want.sat) report("saturated", saturated, want.sat);
        end
      end
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Register write on the next falling edge; the caller drops cfg_we.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx <= REG_CELL_YZ_ZZ) box_reg[idx[1:0]] = val;
    else if (idx <= REG_INVERSE_YZ_ZZ) inv_reg[2'(idx - REG_INVERSE_XX_XY)] = val;
    else if (idx == REG_PERIODIC_EN) wrap_on = val[0];
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Loads a cell and a matching inverse built from it in floating point.
  task automatic load_lattice(real lo, real hi, real skew);
    real ux, uy, uz, uxy, uxz, uyz;
    logic [31:0] q [6];
    ux = lo + (hi - lo) * $urandom_range(1000) / 1000.0;
    uy = lo + (hi - lo) * $urandom_range(1000) / 1000.0;
    uz = lo + (hi - lo) * $urandom_range(1000) / 1000.0;
    uxy = skew * ux * ($urandom_range(2000) / 1000.0 - 1.0);
    uxz = skew * ux * ($urandom_range(2000) / 1000.0 - 1.0);
    uyz = skew * uy * ($urandom_range(2000) / 1000.0 - 1.0);
    q[0] = $rtoi(ux * 65536.0);  q[1] = $rtoi(uxy * 65536.0);
    q[2] = $rtoi(uxz * 65536.0); q[3] = $rtoi(uy * 65536.0);
    q[4] = $rtoi(uyz * 65536.0); q[5] = $rtoi(uz * 65536.0);
    write_reg(REG_CELL_XX_XY, {q[0], q[1]});
    write_reg(REG_CELL_XZ_YY, {q[2], q[3]});
    write_reg(REG_CELL_YZ_ZZ, {q[4], q[5]});
    q[0] = $rtoi(16777216.0 / ux);
    q[1] = $rtoi(-16777216.0 * uxy / (ux * uy));
    q[2] = $rtoi(16777216.0 * (uxy * uyz - uxz * uy) / (ux * uy * uz));
    q[3] = $rtoi(16777216.0 / uy);
    q[4] = $rtoi(-16777216.0 * uyz / (uy * uz));
    q[5] = $rtoi(16777216.0 / uz);
    write_reg(REG_INVERSE_XX_XY, {q[0], q[1]});
    write_reg(REG_INVERSE_XZ_YY, {q[2], q[3]});
    write_reg(REG_INVERSE_YZ_ZZ, {q[4], q[5]});
    write_reg(REG_PERIODIC_EN, {$urandom, $urandom} | 64'd1);
    end_writes();
  endtask

  task automatic add_point(logic op, int x, int y, int z, int a, int b, int c,
                           logic org, logic near);
    point_t it;
    it.op = op; it.x = x; it.y = y; it.z = z;
    it.a = SHIFT_W'(a); it.b = SHIFT_W'(b); it.c = SHIFT_W'(c);
    it.org = org; it.near = near;
    pend_q.push_back(it);
  endtask

  // Random beats: mostly near the cell with small shifts, some full range.
  task automatic add_random(int count, int span);
    point_t it;
    repeat (count) begin
      it.op = ($urandom_range(3) == 0) ? OP_VECTOR : OP_POINT;
      if ($urandom_range(9) < 7) begin
        it.x = $urandom_range(2 * span) - span;
        it.y = $urandom_range(2 * span) - span;
        it.z = $urandom_range(2 * span) - span;
      end else begin
        it.x = $urandom; it.y = $urandom; it.z = $urandom;
      end
      if ($urandom_range(9) < 8) begin
        it.a = SHIFT_W'($urandom_range(6) - 3);
        it.b = SHIFT_W'($urandom_range(6) - 3);
        it.c = SHIFT_W'($urandom_range(6) - 3);
      end else begin
        it.a = SHIFT_W'($urandom); it.b = SHIFT_W'($urandom); it.c = SHIFT_W'($urandom);
      end
      it.org = 1'($urandom);
      it.near = 1'($urandom);
      pend_q.push_back(it);
    end
  endtask

  // Waits until every beat is sent and checked, then lets the block settle.
  task automatic wait_idle();
    while (pend_q.size() > 0 || image_q.size() > 0 || in_valid) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      box_reg[i] = '0;
      inv_reg[i] = '0;
    end
    wrap_on = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Disabled after reset: everything passes straight through.
    add_point(OP_POINT, 32'h7fffffff, 32'h80000000, 0, 127, -128, 0, 1, 1);
    add_point(OP_VECTOR, 32'h80000000, 32'h7fffffff, -1, -1, -1, -1, 1, 1);
    add_point(OP_POINT, 123456, -654321, 42, 3, 4, 5, 0, 0);
    wait_idle();

    // A skewed 20 to 30 unit cell: extremes, every mode, shifts at the rails.
    load_lattice(20.0, 30.0, 0.3);
    add_point(OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0);
    add_point(OP_POINT, 0, 0, 0, 0, 0, 0, 0, 1);
    add_point(OP_POINT, 5 << 16, -7 << 16, 33 << 16, 0, 0, 0, 1, 0);
    add_point(OP_POINT, 5 << 16, -7 << 16, 33 << 16, 1, -1, 2, 1, 1);
    add_point(OP_POINT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0, 1);
    add_point(OP_POINT, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 1, 0);
    add_point(OP_POINT, 1, -1, 32'h7fffffff, 127, 127, 127, 1, 0);
    add_point(OP_POINT, -1, 1, 32'h80000000, -128, -128, -128, 0, 1);
    add_point(OP_POINT, 1 << 16, 2 << 16, 3 << 16, 127, -128, 127, 1, 1);
    add_point(OP_VECTOR, 0, 0, 0, 0, 0, 0, 0, 0);
    add_point(OP_VECTOR, 31 << 16, -29 << 16, 45 << 16, 127, -128, 5, 1, 0);
    add_point(OP_VECTOR, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 1);
    add_point(OP_VECTOR, 32'h80000000, 32'h7fffffff, 32'h80000000, -1, 1, 0, 1, 1);
    add_point(OP_POINT, 32'hffffffff, 32'hffffffff, 32'hffffffff, -1, -1, -1, 1, 1);
    wait_idle();

    // Ordinary cells of several sizes, one phase without any idling.
    for (int ph = 0; ph < 5; ph++) begin
      quiet = (ph == 2);
      load_lattice(8.0 + 20.0 * ph, 15.0 + 40.0 * ph, 0.1 * ph);
      add_random(110, (20 + 60 * ph) << 16);
      wait_idle();
    end
    quiet = 0;

    // Large cells so that big shifts run off the coordinate range.
    load_lattice(200.0, 400.0, 0.4);
    add_random(110, 1000 << 16);
    wait_idle();

    // Raw register contents: all ones, then random, plus an unused index.
    for (int i = 0; i < 3; i++) write_reg(CFG_IDX_W'(REG_CELL_XX_XY + i), '1);
    for (int i = 0; i < 3; i++) write_reg(CFG_IDX_W'(REG_INVERSE_XX_XY + i), '1);
    write_reg(REG_UNUSED, '1);
    end_writes();
    add_random(70, 100 << 16);
    wait_idle();
    for (int i = 0; i < 3; i++)
      write_reg(CFG_IDX_W'(REG_CELL_XX_XY + i), {$urandom, $urandom});
    for (int i = 0; i < 3; i++)
      write_reg(CFG_IDX_W'(REG_INVERSE_XX_XY + i), {$urandom, $urandom});
    end_writes();
    add_random(70, 100 << 16);
    wait_idle();
    write_reg(REG_CELL_XX_XY, {32'h7fffffff, 32'h80000000});
    write_reg(REG_CELL_XZ_YY, {32'h80000000, 32'h7fffffff});
    write_reg(REG_CELL_YZ_ZZ, {32'h7fffffff, 32'h7fffffff});
    write_reg(REG_INVERSE_XX_XY, {32'h7fffffff, 32'h80000000});
    write_reg(REG_INVERSE_XZ_YY, {32'h80000000, 32'h7fffffff});
    write_reg(REG_INVERSE_YZ_ZZ, '0);
    end_writes();
    add_random(40, 100 << 16);
    wait_idle();

    // Disabled again with cell data still loaded; upper data bits are ignored.
    write_reg(REG_PERIODIC_EN, 64'hffff_ffff_ffff_fffe);
    end_writes();
    add_random(60, 100 << 16);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d of %0d beats (%0d vectors, %0d saturated) over 12 register sets.",
             n_out, n_in, n_vec, n_sat);
    if (errors == 0 && image_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, image_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/pcip_pkg.sv
hw/rtl/pcip_mac.sv
hw/rtl/periodic_cell_image_point_top.sv
hw/rtl/pcip_checker.sv
test/testbench.sv
